>>> sv/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg
// Types and constants for the sorted breakpoint table interpolator.
// ----------------------------------------------------------------------------
package sti_pkg;

    localparam int DEPTH_DEF = 32;

    typedef enum logic [1:0] {
        MD_LOAD  = 2'd0,
        MD_QUERY = 2'd1,
        MD_CLEAR = 2'd2,
        MD_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic signed [15:0] angle;
        logic signed [15:0] lift;
    } t_in;

    typedef struct packed {
        logic signed [15:0] value;
        t_status            status;
    } t_out;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] value;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_SCAN,
        S_Q_SCAN,
        S_Q_DEN,
        S_Q_DV,
        S_Q_DVN,
        S_Q_DX,
        S_Q_MUL,
        S_Q_DIV,
        S_Q_ADD
    } t_state;

endpackage

>>> sv/sorted_table_linear_interpolator_core.sv
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator_core
// Breakpoint table kept in ascending angle order, with exact-match lookup and
// linear interpolation between neighbors through one shared adder/subtractor.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  input     i_word (t_in)              taken when start && !busy
//  result    o_result (t_out)           valid for the one cycle strobe is high
//
//  Load: walk down the table through the memory read port, moving each stored
//  entry with a larger angle up one slot. Query: scan the entries in order,
//  then, when interpolating, the difference steps (one more when the value
//  falls), one multiply and a 16-step restoring divide. Clear resets the count.
//  Synchronous active-low reset empties the table; no clearing pass is needed.
//  The result is shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator_core #(
    parameter int TABLE_DEPTH = sti_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  sti_pkg::t_in  i_word,
    output logic          busy,
    output logic          strobe,
    output sti_pkg::t_out o_result
);
    import sti_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic [3:0] r_cnt, n_cnt;
    logic signed [15:0] r_x, n_x;
    logic signed [15:0] r_lift, n_lift;
    logic signed [15:0] r_pa, n_pa;
    logic signed [15:0] r_pv, n_pv;
    logic signed [15:0] r_ca, n_ca;
    logic signed [15:0] r_cv, n_cv;
    logic [15:0] r_den, n_den;
    logic [15:0] r_mag, n_mag;
    logic [15:0] r_dx, n_dx;
    logic r_neg, n_neg;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_quo, n_quo;
    logic r_strobe, n_strobe;
    t_out r_result, n_result;

    logic [AW-1:0] c_raddr;
    logic c_we;
    logic [AW-1:0] c_waddr;
    t_entry c_wdata;
    logic [17:0] c_sa, c_sb, c_sum;
    logic c_sub;
    logic [16:0] c_trial;
    logic c_accept;

    assign c_accept = start && (r_state == S_IDLE);
    assign c_trial  = {r_rem, r_quo[15]};
    assign c_sum    = c_sub ? (c_sa - c_sb) : (c_sa + c_sb);

    function automatic logic [17:0] sx(input logic signed [15:0] v);
        sx = {{2{v[15]}}, v};
    endfunction

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_mem[c_waddr] <= c_wdata;
        end
        r_rdata <= r_mem[c_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_x      <= n_x;
        r_lift   <= n_lift;
        r_pa     <= n_pa;
        r_pv     <= n_pv;
        r_ca     <= n_ca;
        r_cv     <= n_cv;
        r_den    <= n_den;
        r_mag    <= n_mag;
        r_dx     <= n_dx;
        r_neg    <= n_neg;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_result <= n_result;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_x      = r_x;
        n_lift   = r_lift;
        n_pa     = r_pa;
        n_pv     = r_pv;
        n_ca     = r_ca;
        n_cv     = r_cv;
        n_den    = r_den;
        n_mag    = r_mag;
        n_dx     = r_dx;
        n_neg    = r_neg;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_strobe = 1'b0;
        n_result = r_result;
        c_raddr  = r_idx;
        c_we     = 1'b0;
        c_waddr  = r_idx;
        c_wdata  = '{angle: r_x, value: r_lift};
        c_sa     = sx(r_x);
        c_sb     = sx(r_rdata.angle);
        c_sub    = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    n_x      = i_word.angle;
                    n_lift   = i_word.lift;
                    n_result = '{value: '0, status: ST_OK};
                    case (i_word.mode)
                        MD_LOAD: begin
                            c_raddr = r_count[AW-1:0] - AW'(1);
                            n_idx   = r_count[AW-1:0];
                            if (r_count >= FULL_COUNT) begin
                                n_result.status = ST_FULL;
                                n_strobe        = 1'b1;
                            end else begin
                                n_state = S_LD_SCAN;
                            end
                        end
                        MD_QUERY: begin
                            c_raddr = '0;
                            n_idx   = '0;
                            if (r_count == '0) begin
                                n_result.status = ST_EMPTY;
                                n_strobe        = 1'b1;
                            end else begin
                                n_state = S_Q_SCAN;
                            end
                        end
                        MD_CLEAR: begin
                            n_count  = '0;
                            n_strobe = 1'b1;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_LD_SCAN: begin
                // shift larger entries up one slot, drop the new pair in the gap
                c_raddr = r_idx - AW'(2);
                if (r_idx == '0 || !c_sum[17]) begin
                    c_we     = 1'b1;
                    n_count  = r_count + CW'(1);
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    c_we    = 1'b1;
                    c_wdata = r_rdata;
                    n_idx   = r_idx - AW'(1);
                end
            end
            S_Q_SCAN: begin
                c_raddr = r_idx + AW'(1);
                if (c_sum == '0) begin
                    n_result.value = r_rdata.value;
                    n_strobe       = 1'b1;
                    n_state        = S_IDLE;
                end else if (c_sum[17]) begin
                    n_ca = r_rdata.angle;
                    n_cv = r_rdata.value;
                    if (r_idx == '0) begin
                        n_result.status = ST_RANGE;
                        n_strobe        = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        n_state = S_Q_DEN;
                    end
                end else begin
                    n_pa = r_rdata.angle;
                    n_pv = r_rdata.value;
                    if ({{(CW-AW){1'b0}}, r_idx} == r_count - CW'(1)) begin
                        n_result.status = ST_RANGE;
                        n_strobe        = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            S_Q_DEN: begin
                c_sa    = sx(r_ca);
                c_sb    = sx(r_pa);
                n_den   = c_sum[15:0];
                n_state = S_Q_DV;
            end
            S_Q_DV: begin
                c_sa  = sx(r_cv);
                c_sb  = sx(r_pv);
                n_neg = c_sum[17];
                n_mag = c_sum[15:0];
                n_state = c_sum[17] ? S_Q_DVN : S_Q_DX;
            end
            S_Q_DVN: begin
                c_sa    = sx(r_pv);
                c_sb    = sx(r_cv);
                n_mag   = c_sum[15:0];
                n_state = S_Q_DX;
            end
            S_Q_DX: begin
                c_sa    = sx(r_x);
                c_sb    = sx(r_pa);
                n_dx    = c_sum[15:0];
                n_state = S_Q_MUL;
            end
            S_Q_MUL: begin
                {n_rem, n_quo} = r_dx * r_mag;
                n_cnt   = '0;
                n_state = S_Q_DIV;
            end
            S_Q_DIV: begin
                c_sa  = {1'b0, c_trial};
                c_sb  = {2'b00, r_den};
                n_cnt = r_cnt + 4'd1;
                if (!c_sum[17]) begin
                    n_rem = c_sum[15:0];
                    n_quo = {r_quo[14:0], 1'b1};
                end else begin
                    n_rem = c_trial[15:0];
                    n_quo = {r_quo[14:0], 1'b0};
                end
                if (r_cnt == 4'd15) begin
                    n_state = S_Q_ADD;
                end
            end
            S_Q_ADD: begin
                c_sa           = sx(r_pv);
                c_sb           = {2'b00, r_quo};
                c_sub          = r_neg;
                n_result.value = c_sum[15:0];
                n_strobe       = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign strobe   = r_strobe;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count beyond table depth");

    a_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (strobe || busy))
        else $error("accepted word neither answered nor in progress");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && o_result.status == ST_FULL) |-> (r_count == FULL_COUNT))
        else $error("full status with room left in table");

endmodule
